>>> sv/menu_action_auto_repeat_core_macros.svh
// assertion macros used by the menu action auto-repeat rtl
// no dependencies; included by modules that carry assertions
`ifndef MENU_ACTION_AUTO_REPEAT_CORE_MACROS_SVH
`define MENU_ACTION_AUTO_REPEAT_CORE_MACROS_SVH

// same-cycle implication under reset
`define MAR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define MAR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mar_pkg.sv
// types and constants of the menu action auto-repeat core
// no dependencies
`timescale 1ns / 1ps

package mar_pkg;

	localparam int TDATA_IN_W  = 112;
	localparam int TDATA_OUT_W = 8;
	localparam int THR_W       = 15;
	localparam int TIME_W      = 64;
	localparam int BTN_W       = 12;
	localparam int AXIS_W      = 16;
	localparam int ACT_W       = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [THR_W-1:0]  THR_RESET   = 15'd32700;
	localparam logic [TIME_W-1:0] FIRST_RESET = 64'd500000000;
	localparam logic [TIME_W-1:0] NEXT_RESET  = 64'd100000000;

	// held mask bit positions
	localparam int BTN_DOWN  = 2;
	localparam int BTN_UP    = 3;
	localparam int BTN_LEFT  = 4;
	localparam int BTN_RIGHT = 5;
	localparam int BTN_B     = 8;
	localparam int BTN_A     = 9;

	localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ENTER = 3'd1;
	localparam logic [ACT_W-1:0] ACT_LEAVE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DOWN  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_UP    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_RIGHT = 3'd5;
	localparam logic [ACT_W-1:0] ACT_LEFT  = 3'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AXIS_THRESHOLD = 2'd0,
		CFG_FIRST_DELAY    = 2'd1,
		CFG_NEXT_DELAY     = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FIRST  = 3'b010,
		PH_REPEAT = 3'b100
	} phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] first_delay;
		logic [TIME_W-1:0] next_delay;
	} delay_cfg_t;

endpackage

>>> sv/menu_action_auto_repeat_core.sv
// a transaction is registered in the input stage, then in the output stage that drives m_tvalid
// throughput: one transaction per cycle while the output is not stalled; the cycle holds the 64-bit elapsed-time
// subtract and compare against the repeat delay
// reset: arst_n clears both stages, the hold state and the last emit time, and
// loads the registers with threshold 32700, delays 500000000 and 100000000 ns
`timescale 1ns / 1ps

module menu_action_auto_repeat_core import mar_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// held_buttons[11:0], axis_x[27:12], axis_y[43:28], timestamp[107:44], zero pad
	input  logic [TDATA_IN_W-1:0]   s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// action[2:0], zero pad
	output logic [TDATA_OUT_W-1:0]  m_tdata
);

	logic [THR_W-1:0]        thr_q;
	delay_cfg_t              delays_q;

	logic                    valid_s1;
	logic [BTN_W-1:0]        buttons_s1;
	logic signed [AXIS_W-1:0] x_s1;
	logic signed [AXIS_W-1:0] y_s1;
	logic [TIME_W-1:0]       time_s1;

	logic                    valid_s2;
	logic [ACT_W-1:0]        action_s2;

	logic                    adv;
	logic                    s_accept;
	logic [ACT_W-1:0]        picked;
	logic [ACT_W-1:0]        result;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q                <= THR_RESET;
			delays_q.first_delay <= FIRST_RESET;
			delays_q.next_delay  <= NEXT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_AXIS_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				CFG_FIRST_DELAY:    delays_q.first_delay <= cfg_data[TIME_W-1:0];
				CFG_NEXT_DELAY:     delays_q.next_delay <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			buttons_s1 <= s_tdata[11:0];
			x_s1       <= s_tdata[27:12];
			y_s1       <= s_tdata[43:28];
			time_s1    <= s_tdata[107:44];
		end
	end

	mar_pick u_pick (
		.threshold    (thr_q),
		.held_buttons (buttons_s1),
		.axis_x       (x_s1),
		.axis_y       (y_s1),
		.action       (picked)
	);

	mar_repeat u_repeat (
		.clk       (clk),
		.arst_n    (arst_n),
		.delays    (delays_q),
		.step      (adv),
		.act_in    (picked),
		.timestamp (time_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(TDATA_OUT_W-ACT_W){1'b0}}, action_s2};

endmodule

>>> sv/mar_pick.sv
// axis to direction mapping and priority pick of the held menu key
// depends on mar_pkg
`timescale 1ns / 1ps

module mar_pick import mar_pkg::*; (
	input  logic [THR_W-1:0]        threshold,
	input  logic [BTN_W-1:0]        held_buttons,
	input  logic signed [AXIS_W-1:0] axis_x,
	input  logic signed [AXIS_W-1:0] axis_y,
	output logic [ACT_W-1:0]        action
);

	logic signed [AXIS_W:0] x_ext;
	logic signed [AXIS_W:0] y_ext;
	logic signed [AXIS_W:0] thr_pos;
	logic signed [AXIS_W:0] thr_neg;
	logic [BTN_W-1:0]       btn;

	assign x_ext   = {axis_x[AXIS_W-1], axis_x};
	assign y_ext   = {axis_y[AXIS_W-1], axis_y};
	assign thr_pos = {2'b00, threshold};
	assign thr_neg = -thr_pos;

	always_comb begin
		btn = held_buttons;
		if (x_ext < thr_neg) begin
			btn[BTN_LEFT] = 1'b1;
		end else if (x_ext > thr_pos) begin
			btn[BTN_RIGHT] = 1'b1;
		end
		if (y_ext < thr_neg) begin
			btn[BTN_UP] = 1'b1;
		end else if (y_ext > thr_pos) begin
			btn[BTN_DOWN] = 1'b1;
		end

		if (btn[BTN_A]) begin
			action = ACT_ENTER;
		end else if (btn[BTN_B]) begin
			action = ACT_LEAVE;
		end else if (btn[BTN_DOWN]) begin
			action = ACT_DOWN;
		end else if (btn[BTN_UP]) begin
			action = ACT_UP;
		end else if (btn[BTN_RIGHT]) begin
			action = ACT_RIGHT;
		end else if (btn[BTN_LEFT]) begin
			action = ACT_LEFT;
		end else begin
			action = ACT_NONE;
		end
	end

endmodule

>>> sv/mar_repeat.sv
// typematic repeat state: hold phase, previous action, last emit time
// depends on mar_pkg and the macros header
`timescale 1ns / 1ps
`include "menu_action_auto_repeat_core_macros.svh"

module mar_repeat import mar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  delay_cfg_t         delays,
	input  logic               step,
	input  logic [ACT_W-1:0]   act_in,
	input  logic [TIME_W-1:0]  timestamp,
	output logic [ACT_W-1:0]   result
);

	phase_t             phase_q;
	logic [ACT_W-1:0]   prev_q;
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  elapsed;
	logic [TIME_W-1:0]  need;
	logic               fresh;
	logic               due;

	assign fresh   = (act_in == ACT_NONE) || (act_in != prev_q) || (phase_q == PH_IDLE);
	assign elapsed = timestamp - last_q;

	always_comb begin
		unique case (phase_q)
			PH_FIRST: need = delays.first_delay;
			default:  need = delays.next_delay;
		endcase
	end

	assign due    = elapsed >= need;
	assign result = (fresh || due) ? act_in : ACT_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prev_q  <= ACT_NONE;
			last_q  <= '0;
		end else if (step) begin
			if (fresh) begin
				prev_q  <= act_in;
				last_q  <= timestamp;
				phase_q <= (act_in != ACT_NONE) ? PH_FIRST : PH_IDLE;
			end else if (due) begin
				last_q  <= timestamp;
				phase_q <= PH_REPEAT;
			end
		end
	end

	`MAR_ASSERT_IMP(a_idle_no_prev, clk, arst_n, phase_q == PH_IDLE, prev_q == ACT_NONE, "idle phase with a remembered action")
	`MAR_ASSERT_IMP(a_held_has_prev, clk, arst_n, phase_q != PH_IDLE, prev_q != ACT_NONE, "held phase without an action")
	`MAR_ASSERT_NXT(a_emit_stamps, clk, arst_n, step && result != ACT_NONE, last_q == $past(timestamp), "emit did not record its time")
	`MAR_ASSERT_IMP(a_none_in_none_out, clk, arst_n, act_in == ACT_NONE, result == ACT_NONE, "result without a held action")

endmodule
